FILE: src/swt_pkg.sv
// Shared types, constants and helper functions for the sequence window tracker.
// Depends on nothing; imported by the tracker top level.
package swt_pkg;

	localparam int SID_W = 4;
	localparam int SEQ_W = 32;
	localparam int CNT_W = 32;
	localparam int OUTC_W = 3;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [OUTC_W-1:0] {
		OUT_FIRST     = 3'd0,
		OUT_ADVANCED  = 3'd1,
		OUT_LATE_FILL = 3'd2,
		OUT_DUPLICATE = 3'd3,
		OUT_BEYOND    = 3'd4
	} outcome_t;

	typedef logic [CNT_W-1:0] cnt_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
		logic [CNT_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
	endfunction

endpackage

FILE: src/sequence_window_tracker.sv
// Sequence window tracker: per-stream receive window and loss counters.
// Depends on swt_pkg and swt_ram.
//
// Each request on the slave side is one received packet (stream id and sequence
// number); the block classifies it against that stream's sliding receive window
// and returns one result with the stream's updated counters and the global
// duplicate and out-of-order totals. For each packet the state row is read from
// the per-stream memory, evaluated, then updated and written back, and no new
// packet is taken until that read-evaluate-write sequence on the single state
// memory is done. A stalled result holds the update stage, and the next packet
// is taken while a result waits. Packets whose stream id is not below
// NUM_STREAMS are consumed without leaving the idle state and produce no result.
// Per-stream valid bits in flip-flops make every stream read as zero after
// reset, so there is no clearing pass.
module sequence_window_tracker #(
	parameter int NUM_STREAMS = 16,
	parameter int WINDOW_BITS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,   // stream_num[3:0], seq_number[35:4], zero pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [199:0] m_tdata    // stream_echo[3:0], outcome[6:4],
	                                // stream_missing[38:7], stream_received[70:39],
	                                // stream_dups[102:71], stream_late[134:103],
	                                // total_dups[166:135], total_late[198:167], pad
);

	import swt_pkg::*;

	localparam int AW     = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
	localparam int IDXW   = $clog2(WINDOW_BITS);
	localparam int ROW_W  = WINDOW_BITS + 5 * CNT_W;
	localparam int HI_LO  = WINDOW_BITS;
	localparam int MIS_LO = WINDOW_BITS + CNT_W;
	localparam int RCV_LO = WINDOW_BITS + 2 * CNT_W;
	localparam int DUP_LO = WINDOW_BITS + 3 * CNT_W;
	localparam int LAT_LO = WINDOW_BITS + 4 * CNT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_UPD
	} state_t;

	state_t state_q;

	// Input unpacking.
	logic [SID_W-1:0] in_sid;
	logic [SEQ_W-1:0] in_seq;
	logic             in_range;
	logic [AW-1:0]    in_addr;
	logic             accept;

	assign in_sid   = s_tdata[3:0];
	assign in_seq   = s_tdata[35:4];
	assign in_range = 9'(in_sid) < 9'(NUM_STREAMS);
	assign in_addr  = AW'(in_sid);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Request captured at accept.
	logic [SID_W-1:0] sid_s1;
	logic [SEQ_W-1:0] seq_s1;
	logic [AW-1:0]    addr_s1;
	logic             seen_s1;

	// Evaluation results.
	outcome_t         outc_s2;
	logic             wide_s2;
	logic [IDXW-1:0]  idx_s2;
	cnt_t             gap_s2;

	logic [NUM_STREAMS-1:0] seen_q;
	cnt_t                   dup_total_q;
	cnt_t                   late_total_q;

	// State memory.
	logic             ram_we;
	logic [ROW_W-1:0] ram_wdata;
	logic [ROW_W-1:0] ram_rdata;

	swt_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_STREAMS)
	) u_row_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (ram_wdata),
		.re    (accept && in_range),
		.raddr (in_addr),
		.rdata (ram_rdata)
	);

	// A stream never written reads as all zero.
	logic [ROW_W-1:0]       row;
	logic [WINDOW_BITS-1:0] win;
	logic [SEQ_W-1:0]       hi;
	cnt_t                   mis, rcv, dup, lat;

	assign row = seen_s1 ? ram_rdata : '0;
	assign win = row[WINDOW_BITS-1:0];
	assign hi  = row[HI_LO +: SEQ_W];
	assign mis = row[MIS_LO +: CNT_W];
	assign rcv = row[RCV_LO +: CNT_W];
	assign dup = row[DUP_LO +: CNT_W];
	assign lat = row[LAT_LO +: CNT_W];

	// Evaluate stage: classify the packet against the window.
	logic [SEQ_W-1:0] d_up, d_dn;
	outcome_t         ev_outc;
	logic             ev_wide;
	logic [IDXW-1:0]  ev_idx;

	assign d_up = seq_s1 - hi;
	assign d_dn = hi - seq_s1;

	always_comb begin
		ev_outc = OUT_FIRST;
		ev_wide = 1'b0;
		ev_idx  = d_dn[IDXW-1:0];
		if (!seen_s1) begin
			ev_outc = OUT_FIRST;
		end else if (seq_s1 > hi) begin
			ev_outc = OUT_ADVANCED;
			ev_wide = d_up >= SEQ_W'(WINDOW_BITS);
			ev_idx  = d_up[IDXW-1:0];
		end else if (d_dn >= SEQ_W'(WINDOW_BITS)) begin
			ev_outc = OUT_BEYOND;
		end else if (win[d_dn[IDXW-1:0]]) begin
			ev_outc = OUT_DUPLICATE;
		end else begin
			ev_outc = OUT_LATE_FILL;
		end
	end

	// Update stage: new row and result.
	logic [WINDOW_BITS-1:0] n_win;
	logic [SEQ_W-1:0]       n_hi;
	cnt_t                   n_mis, n_rcv, n_dup, n_lat, n_dtot, n_ltot;
	logic                   out_free;
	logic                   commit;

	always_comb begin
		n_win  = win;
		n_hi   = hi;
		n_mis  = mis;
		n_rcv  = sat_inc(rcv);
		n_dup  = dup;
		n_lat  = lat;
		n_dtot = dup_total_q;
		n_ltot = late_total_q;
		case (outc_s2)
			OUT_FIRST: begin
				n_hi  = seq_s1;
				n_win = WINDOW_BITS'(1);
				n_mis = seq_s1;
			end
			OUT_ADVANCED: begin
				n_hi  = seq_s1;
				n_mis = sat_add(mis, gap_s2);
				n_win = wide_s2 ? WINDOW_BITS'(1) : ((win << idx_s2) | WINDOW_BITS'(1));
			end
			OUT_LATE_FILL: begin
				n_win  = win | (WINDOW_BITS'(1) << idx_s2);
				n_lat  = sat_inc(lat);
				n_ltot = sat_inc(late_total_q);
				n_mis  = (mis != '0) ? mis - 1'b1 : mis;
			end
			OUT_DUPLICATE: begin
				n_dup  = sat_inc(dup);
				n_dtot = sat_inc(dup_total_q);
			end
			OUT_BEYOND: begin
				n_lat  = sat_inc(lat);
				n_ltot = sat_inc(late_total_q);
			end
			default: begin
				n_win = win;
			end
		endcase
	end

	assign ram_wdata = {n_lat, n_dup, n_rcv, n_mis, n_hi, n_win};
	assign out_free  = !m_tvalid || m_tready;
	assign commit    = (state_q == ST_UPD) && out_free;
	assign ram_we    = commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			m_tvalid     <= 1'b0;
			seen_q       <= '0;
			dup_total_q  <= '0;
			late_total_q <= '0;
		end else begin
			m_tvalid <= commit || (m_tvalid && !m_tready);
			case (state_q)
				ST_IDLE: begin
					if (accept && in_range) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (out_free) begin
						state_q          <= ST_IDLE;
						seen_q[addr_s1]  <= 1'b1;
						dup_total_q      <= n_dtot;
						late_total_q     <= n_ltot;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			sid_s1  <= in_sid;
			seq_s1  <= in_seq;
			addr_s1 <= in_addr;
			seen_s1 <= seen_q[in_addr];
		end
		if (state_q == ST_EVAL) begin
			outc_s2 <= ev_outc;
			wide_s2 <= ev_wide;
			idx_s2  <= ev_idx;
			gap_s2  <= d_up - 1'b1;
		end
		if (commit) begin
			m_tdata <= {1'b0, n_ltot, n_dtot, n_lat, n_dup, n_rcv, n_mis, outc_s2, sid_s1};
		end
	end

	// A result that cannot leave keeps the update stage and its write back.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) && !out_free |-> !ram_we ##1 (state_q == ST_UPD))
		else $error("update stage left while the result register was busy");

	// Every write back presents a result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> m_tvalid)
		else $error("state written back without a result");

	// A written stream is marked as seen.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> seen_q[$past(addr_s1)])
		else $error("stream written but not marked seen");

	// Totals change only in the update stage; they never decrease.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_UPD |=> (dup_total_q == $past(dup_total_q))
		&& (late_total_q == $past(late_total_q)))
		else $error("totals changed outside the update stage");

	// No new request is taken before the current one is written back.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> !s_tready)
		else $error("request accepted during evaluation");

endmodule

FILE: src/swt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module swt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
